// ----- src/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, widths and the control program of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int MEAS_WIDTH  = 24;
  localparam int VAL_W       = 32;
  localparam int GAIN_W      = 17;
  localparam int FRAC_W      = 16;
  localparam int IN_TDATA_W  = ((MEAS_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELD_W = VAL_W + VAL_W + GAIN_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int MEAS_SH_W = MEAS_WIDTH + 8;
  localparam int DIFF_W    = ((MEAS_SH_W > VAL_W) ? MEAS_SH_W : VAL_W) + 1;
  localparam int MCAND_W   = (DIFF_W > VAL_W + 1) ? DIFF_W : VAL_W + 1;
  localparam int PROD_W    = MCAND_W + GAIN_W;
  localparam int EST_SUM_W = PROD_W - FRAC_W + 1;
  localparam int NUM_W     = VAL_W + FRAC_W + 1;
  localparam int REM_W     = VAL_W + 1;
  localparam int CNT_W     = $clog2(GAIN_W);

  localparam logic [CNT_W-1:0]  ITER_LAST = CNT_W'(GAIN_W - 1);
  localparam logic [GAIN_W-1:0] ONE_GAIN  = GAIN_W'(1) << FRAC_W;
  localparam logic [VAL_W-1:0]  ONE_Q16   = VAL_W'(1) << FRAC_W;

  localparam int CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_PROCESS_NOISE     = 2'd0,
    REG_MEASUREMENT_NOISE = 2'd1,
    REG_INITIAL_ESTIMATE  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [VAL_W-1:0]        process_noise;
    logic [VAL_W-1:0]        measurement_noise;
    logic signed [VAL_W-1:0] initial_estimate;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DEN,
    OP_NUM,
    OP_DIV,
    OP_GAIN,
    OP_MUL,
    OP_EST,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    C_NEXT,
    C_NO_INPUT,
    C_CNT_NZ,
    C_OUT_BUSY
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_DIV   = 4'd3;
  localparam step_t STEP_MUL_K = 4'd5;
  localparam step_t STEP_MUL_P = 4'd7;
  localparam step_t STEP_LAST  = 4'd8;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } dp_ctrl_t;

  typedef struct packed {
    logic cnt_nz;
    logic out_busy;
  } dp_stat_t;

  // A taken condition jumps to the target; otherwise the program advances,
  // and the last step wraps to the idle step.
  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_LOAD, cond: C_NO_INPUT, target: STEP_IDLE};
      4'd1:    w = '{op: OP_DEN,  cond: C_NEXT,     target: STEP_IDLE};
      4'd2:    w = '{op: OP_NUM,  cond: C_NEXT,     target: STEP_IDLE};
      4'd3:    w = '{op: OP_DIV,  cond: C_CNT_NZ,   target: STEP_DIV};
      4'd4:    w = '{op: OP_GAIN, cond: C_NEXT,     target: STEP_IDLE};
      4'd5:    w = '{op: OP_MUL,  cond: C_CNT_NZ,   target: STEP_MUL_K};
      4'd6:    w = '{op: OP_EST,  cond: C_NEXT,     target: STEP_IDLE};
      4'd7:    w = '{op: OP_MUL,  cond: C_CNT_NZ,   target: STEP_MUL_P};
      4'd8:    w = '{op: OP_EMIT, cond: C_OUT_BUSY, target: STEP_LAST};
      default: w = '{op: OP_LOAD, cond: C_NO_INPUT, target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- src/scalar_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional fixed-point Kalman filter over a stream of sensor words.
// ----------------------------------------------------------------------------
// Input words are taken only while the control program is idle, so a new word waits
// until the last one has passed the 17-step serial divider and the two 17-step
// serial multiplications of the control program.
// A result waiting at the output holds the program at its final step.
// Reset (synchronous, rst_n low) loads the register defaults, an estimate of
// zero and a covariance of 1.0, and leaves the output empty.
module scalar_kalman_filter import skf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // measurement
  input  logic                   in_tuser,   // reinit
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // estimate, error_covariance, gain
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t                    cfg;
  dp_ctrl_t                ctrl;
  dp_stat_t                stat;
  logic signed [VAL_W-1:0] estimate;
  logic [VAL_W-1:0]        error_covariance;
  logic [GAIN_W-1:0]       gain;

  skf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  skf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .in_tready (in_tready),
    .ctrl      (ctrl)
  );

  skf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .cfg            (cfg),
    .meas           (in_tdata[MEAS_WIDTH-1:0]),
    .reinit         (in_tuser),
    .out_tready     (out_tready),
    .stat           (stat),
    .out_tvalid     (out_tvalid),
    .out_estimate   (estimate),
    .out_covariance (error_covariance),
    .out_gain       (gain)
  );

  assign out_tdata = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, gain, error_covariance, estimate};

endmodule

// ----- src/skf_cfg.sv -----
// ----------------------------------------------------------------------------
// skf_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module skf_cfg import skf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic [VAL_W-1:0] q_r, q_nxt;
  logic [VAL_W-1:0] r_r, r_nxt;
  logic [VAL_W-1:0] init_r, init_nxt;
  logic [1:0]       idx;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[CFG_AW-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    init_nxt = init_r;
    if (wr_en) begin
      case (idx)
        REG_PROCESS_NOISE:     q_nxt    = cfg_pwdata;
        REG_MEASUREMENT_NOISE: r_nxt    = cfg_pwdata;
        REG_INITIAL_ESTIMATE:  init_nxt = cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROCESS_NOISE:     cfg_prdata = q_r;
      REG_MEASUREMENT_NOISE: cfg_prdata = r_r;
      REG_INITIAL_ESTIMATE:  cfg_prdata = init_r;
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= 32'd655;
      r_r    <= ONE_Q16;
      init_r <= '0;
    end else begin
      q_r    <= q_nxt;
      r_r    <= r_nxt;
      init_r <= init_nxt;
    end
  end

  assign cfg.process_noise     = q_r;
  assign cfg.measurement_noise = r_r;
  assign cfg.initial_estimate  = init_r;

endmodule

// ----- src/skf_seq.sv -----
// ----------------------------------------------------------------------------
// skf_seq
// Step counter and control store that drive the filter datapath.
// ----------------------------------------------------------------------------
module skf_seq import skf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  dp_stat_t stat,
  output logic     in_tready,
  output dp_ctrl_t ctrl
);

  step_t  pc_r, pc_nxt;
  uword_t uw;
  logic   jump;

  assign uw        = ucode(pc_r);
  assign in_tready = (pc_r == STEP_IDLE);
  assign ctrl.op   = uw.op;
  assign ctrl.fire = in_tvalid && in_tready;

  always_comb begin
    case (uw.cond)
      C_NEXT:     jump = 1'b0;
      C_NO_INPUT: jump = !in_tvalid;
      C_CNT_NZ:   jump = stat.cnt_nz;
      C_OUT_BUSY: jump = stat.out_busy;
      default:    jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      pc_nxt = uw.target;
    end else if (pc_r == STEP_LAST) begin
      pc_nxt = STEP_IDLE;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- src/skf_dp.sv -----
// ----------------------------------------------------------------------------
// skf_dp
// Filter datapath: state, bit-serial divider and multiplier, output register.
// ----------------------------------------------------------------------------
module skf_dp import skf_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_ctrl_t                     ctrl,
  input  cfg_t                         cfg,
  input  logic signed [MEAS_WIDTH-1:0] meas,
  input  logic                         reinit,
  input  logic                         out_tready,
  output dp_stat_t                     stat,
  output logic                         out_tvalid,
  output logic signed [VAL_W-1:0]      out_estimate,
  output logic [VAL_W-1:0]             out_covariance,
  output logic [GAIN_W-1:0]            out_gain
);

  logic signed [VAL_W-1:0]      x_r, x_nxt;
  logic [VAL_W-1:0]             p_r, p_nxt;
  logic signed [MEAS_WIDTH-1:0] meas_r, meas_nxt;
  logic [VAL_W-1:0]             p1_r, p1_nxt;
  logic [REM_W-1:0]             den_r, den_nxt;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic [GAIN_W-1:0]            sh_r, sh_nxt;
  logic [GAIN_W-1:0]            k_r, k_nxt;
  logic signed [MCAND_W-1:0]    mcand_r, mcand_nxt;
  logic signed [PROD_W-1:0]     acc_r, acc_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         ov_r, ov_nxt;
  logic signed [VAL_W-1:0]      oe_r, oe_nxt;
  logic [VAL_W-1:0]             oc_r, oc_nxt;
  logic [GAIN_W-1:0]            og_r, og_nxt;

  logic [VAL_W-1:0]                p_sel;
  logic [VAL_W:0]                  p_sum;
  logic [VAL_W-1:0]                p1_sat;
  logic [NUM_W-1:0]                num;
  logic [REM_W:0]                  shifted;
  logic [REM_W+1:0]                trial;
  logic                            ge;
  logic [GAIN_W-1:0]               k_val;
  logic signed [MCAND_W-1:0]       meas_ext;
  logic signed [MCAND_W-1:0]       d_val;
  logic signed [PROD_W-1:0]        addend;
  logic signed [PROD_W-FRAC_W-1:0] q_hi;
  logic [EST_SUM_W-1:0]            est_sum;
  logic signed [VAL_W-1:0]         est_sat;
  logic [VAL_W-1:0]                cov_val;

  always_comb begin
    p_sel   = reinit ? ONE_Q16 : p_r;
    p_sum   = {1'b0, p_sel} + {1'b0, cfg.process_noise};
    p1_sat  = p_sum[VAL_W] ? '1 : p_sum[VAL_W-1:0];
    num     = {1'b0, p1_r, {FRAC_W{1'b0}}} + NUM_W'(den_r[REM_W-1:1]);
    shifted = {rem_r, sh_r[GAIN_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
    ge      = !trial[REM_W+1];
    if (den_r == '0) begin
      k_val = ONE_GAIN;
    end else if (sh_r > ONE_GAIN) begin
      k_val = ONE_GAIN;
    end else begin
      k_val = sh_r;
    end
    meas_ext = MCAND_W'(meas_r);
    d_val    = (meas_ext <<< 8) - MCAND_W'(x_r);
    addend   = sh_r[GAIN_W-1] ? PROD_W'(mcand_r) : '0;
    q_hi     = acc_r[PROD_W-1:FRAC_W];
    est_sum  = EST_SUM_W'(x_r) + EST_SUM_W'(q_hi) + EST_SUM_W'(acc_r[FRAC_W-1]);
    if (est_sum[EST_SUM_W-1:VAL_W-1] == '0 || est_sum[EST_SUM_W-1:VAL_W-1] == '1) begin
      est_sat = est_sum[VAL_W-1:0];
    end else if (est_sum[EST_SUM_W-1]) begin
      est_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      est_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
    cov_val = acc_r[FRAC_W +: VAL_W] + VAL_W'(acc_r[FRAC_W-1]);
  end

  always_comb begin
    x_nxt     = x_r;
    p_nxt     = p_r;
    meas_nxt  = meas_r;
    p1_nxt    = p1_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    k_nxt     = k_r;
    mcand_nxt = mcand_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_tready;
    oe_nxt    = oe_r;
    oc_nxt    = oc_r;
    og_nxt    = og_r;
    case (ctrl.op)
      OP_LOAD: begin
        if (ctrl.fire) begin
          meas_nxt = meas;
          p1_nxt   = p1_sat;
          if (reinit) begin
            x_nxt = cfg.initial_estimate;
          end
        end
      end
      OP_DEN: begin
        den_nxt = {1'b0, p1_r} + {1'b0, cfg.measurement_noise};
      end
      OP_NUM: begin
        rem_nxt = {1'b0, num[NUM_W-1:GAIN_W]};
        sh_nxt  = num[GAIN_W-1:0];
        cnt_nxt = ITER_LAST;
      end
      OP_DIV: begin
        rem_nxt = ge ? trial[REM_W-1:0] : shifted[REM_W-1:0];
        sh_nxt  = {sh_r[GAIN_W-2:0], ge};
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_GAIN: begin
        k_nxt     = k_val;
        sh_nxt    = k_val;
        mcand_nxt = d_val;
        acc_nxt   = '0;
        cnt_nxt   = ITER_LAST;
      end
      OP_MUL: begin
        acc_nxt = (acc_r <<< 1) + addend;
        sh_nxt  = {sh_r[GAIN_W-2:0], 1'b0};
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_EST: begin
        x_nxt     = est_sat;
        mcand_nxt = {{(MCAND_W-VAL_W){1'b0}}, p1_r};
        sh_nxt    = ONE_GAIN - k_r;
        acc_nxt   = '0;
        cnt_nxt   = ITER_LAST;
      end
      OP_EMIT: begin
        if (!ov_r) begin
          p_nxt  = cov_val;
          ov_nxt = 1'b1;
          oe_nxt = x_r;
          oc_nxt = cov_val;
          og_nxt = k_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      p_r   <= ONE_Q16;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      x_r   <= x_nxt;
      p_r   <= p_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r  <= meas_nxt;
    p1_r    <= p1_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    sh_r    <= sh_nxt;
    k_r     <= k_nxt;
    mcand_r <= mcand_nxt;
    acc_r   <= acc_nxt;
    oe_r    <= oe_nxt;
    oc_r    <= oc_nxt;
    og_r    <= og_nxt;
  end

  assign stat.cnt_nz   = (cnt_r != '0);
  assign stat.out_busy = ov_r;
  assign out_tvalid     = ov_r;
  assign out_estimate   = oe_r;
  assign out_covariance = oc_r;
  assign out_gain       = og_r;

endmodule

// ----- dv/tb_scalar_kalman_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter
// Self-checking testbench for the one-dimensional fixed-point Kalman filter.
// A queue of pending sample words feeds a clocked driver; a clocked monitor
// predicts the estimate, covariance and gain of every accepted word and
// compares each result word against the oldest prediction. Register settings
// change between phases while the filter is idle, covering zero noise, the
// saturating noise values and the extreme initial estimates.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_filter import skf_pkg::*; ();

  localparam int            HALF_PERIOD   = 6;
  localparam int            STALL_LIMIT   = 2000;
  localparam int            PHASE_ITEMS   = 240;
  localparam longint        EST_MAX       = 64'sd2147483647;
  localparam longint        EST_MIN       = -64'sd2147483648;
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED = CFG_AW'(12);

  typedef struct {
    logic signed [MEAS_WIDTH-1:0] meas;
    logic                         reinit;
  } sample_word_t;

  typedef struct {
    logic [VAL_W-1:0]  est;
    logic [VAL_W-1:0]  cov;
    logic [GAIN_W-1:0] gain;
  } filter_out_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // measurement
  logic                   in_tuser = 1'b0;  // reinit
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // estimate, error_covariance, gain
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [31:0]            cfg_pwdata = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  scalar_kalman_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #HALF_PERIOD clk = ~clk;

  sample_word_t      pending_samples[$];
  filter_out_t       expected_outputs[$];
  int                words_in_flight = 0;
  int                errors = 0;
  int                quiet_cycles = 0;
  logic              in_taken = 1'b0;
  logic              calm = 1'b0;

  logic [VAL_W-1:0]        q_noise;
  logic [VAL_W-1:0]        r_noise;
  logic signed [VAL_W-1:0] est_init;
  logic signed [VAL_W-1:0] est_state;
  logic [VAL_W-1:0]        cov_state;

  function automatic logic [CFG_AW-1:0] reg_addr(reg_idx_t idx);
    return CFG_AW'({idx, 2'b00});
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("mismatch in %s: expected %h, got %h", what, want, got);
    errors++;
  endtask

  task automatic predict_filter_step(logic signed [MEAS_WIDTH-1:0] meas, logic reinit);
    longint unsigned p1, den, k, cov_next;
    longint          meas_l, est_l, d, x;
    filter_out_t     res;
    if (reinit) begin
      est_state = est_init;
      cov_state = ONE_Q16;
    end
    meas_l = meas;
    est_l  = est_state;
    p1 = {32'b0, cov_state} + {32'b0, q_noise};
    if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
    den = p1 + {32'b0, r_noise};
    if (den == 0) k = 65536;
    else k = (p1 * 65536 + den / 2) / den;
    if (k > 65536) k = 65536;
    d = meas_l * 256 - est_l;
    x = est_l + ((longint'(k) * d + 64'sd32768) >>> 16);
    if (x > EST_MAX) x = EST_MAX;
    if (x < EST_MIN) x = EST_MIN;
    cov_next = ((65536 - k) * p1 + 32768) >> 16;
    if (cov_next > 64'hFFFF_FFFF) cov_next = 64'hFFFF_FFFF;
    est_state = x[VAL_W-1:0];
    cov_state = cov_next[VAL_W-1:0];
    res.est  = est_state;
    res.cov  = cov_state;
    res.gain = k[GAIN_W-1:0];
    expected_outputs.push_back(res);
  endtask

  // Monitor: register writes, accepted samples, result words and the watchdog.
  always @(posedge clk) begin
    filter_out_t want;
    logic        active;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      active = 1'b0;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        active = 1'b1;
        if (cfg_paddr[1:0] == 2'b00) begin
          case (cfg_paddr[CFG_AW-1:2])
            REG_PROCESS_NOISE:     q_noise = cfg_pwdata;
            REG_MEASUREMENT_NOISE: r_noise = cfg_pwdata;
            REG_INITIAL_ESTIMATE:  est_init = cfg_pwdata;
            default: ;
          endcase
        end
      end
      if (in_tvalid && in_tready) begin
        active = 1'b1;
        predict_filter_step(in_tdata[MEAS_WIDTH-1:0], in_tuser);
      end
      if (out_tvalid && out_tready) begin
        active = 1'b1;
        if (expected_outputs.size() == 0) begin
          report_mismatch("unexpected result word", 0, out_tdata[VAL_W-1:0]);
        end else begin
          want = expected_outputs.pop_front();
          words_in_flight--;
          if (out_tdata[VAL_W-1:0] !== want.est)
            report_mismatch("estimate", want.est, out_tdata[VAL_W-1:0]);
          if (out_tdata[2*VAL_W-1:VAL_W] !== want.cov)
            report_mismatch("error_covariance", want.cov, out_tdata[2*VAL_W-1:VAL_W]);
          if (out_tdata[OUT_FIELD_W-1:2*VAL_W] !== want.gain)
            report_mismatch("gain", want.gain, out_tdata[OUT_FIELD_W-1:2*VAL_W]);
        end
      end
      in_taken <= in_tvalid && in_tready;
      if (active) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Driver: presents pending sample words and throttles the result side.
  always @(negedge clk) begin
    sample_word_t w;
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
          words_in_flight++;
          w = pending_samples.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'(w.meas);
          in_tuser  <= w.reinit;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= calm || ($urandom_range(99) >= 17);
    end
  end

  task automatic queue_sample(int meas, logic reinit);
    sample_word_t w;
    w.meas   = MEAS_WIDTH'(meas);
    w.reinit = reinit;
    pending_samples.push_back(w);
  endtask

  task automatic queue_random_samples(int n);
    int v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0, 1: v = $urandom;
        2:    v = $urandom_range(2000) - 1000;
        default: v = $urandom_range(1) ? 8388607 - $urandom_range(15)
                                         : -8388608 + $urandom_range(15);
      endcase
      queue_sample(v, $urandom_range(19) == 0);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || words_in_flight != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk);
    while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_filter_regs(logic [31:0] q, logic [31:0] r, logic [31:0] x0);
    write_reg(reg_addr(REG_PROCESS_NOISE), q);
    write_reg(reg_addr(REG_MEASUREMENT_NOISE), r);
    write_reg(reg_addr(REG_INITIAL_ESTIMATE), x0);
  endtask

  initial begin
    q_noise   = 32'd655;
    r_noise   = 32'd65536;
    est_init  = '0;
    est_state = '0;
    cov_state = ONE_Q16;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_sample(8388607, 1'b0);
    queue_sample(-8388608, 1'b0);
    queue_sample(0, 1'b1);
    queue_sample(-1, 1'b0);
    queue_sample(8388607, 1'b1);
    queue_sample(12345, 1'b0);
    wait_drained();

    // Zero noise drives the covariance to zero, so the denominator vanishes.
    set_filter_regs(32'd0, 32'd0, 32'h7FFF_FFFF);
    queue_sample(8388607, 1'b1);
    queue_sample(-8388608, 1'b0);
    queue_sample(-8388608, 1'b0);
    queue_sample(8388607, 1'b0);
    queue_sample(0, 1'b0);
    wait_drained();

    set_filter_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    queue_sample(8388607, 1'b1);
    queue_sample(8388607, 1'b0);
    queue_sample(-8388608, 1'b0);
    queue_sample(0, 1'b0);
    wait_drained();

    set_filter_regs(32'hFFFF_FFFF, 32'd0, 32'h0000_0100);
    queue_sample(0, 1'b1);
    queue_sample(100, 1'b0);
    queue_sample(-100, 1'b0);
    wait_drained();

    // A write to an unmapped address must leave every register unchanged.
    write_reg(ADDR_UNMAPPED, $urandom);
    queue_sample(5, 1'b0);
    queue_sample(6, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_filter_regs(32'd655, 32'd65536, 32'd0);
        1: set_filter_regs($urandom_range(65536), $urandom_range(1 << 20), $urandom);
        2: set_filter_regs(32'd0, 32'd0, $urandom);
        3: set_filter_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        4: set_filter_regs($urandom, $urandom, $urandom);
        5: set_filter_regs(32'd0, 32'hFFFF_FFFF, 32'h8000_0000);
        6: set_filter_regs($urandom_range(4096), 32'd0, $urandom);
        default: set_filter_regs($urandom_range(1 << 18), $urandom_range(1 << 18), $urandom);
      endcase
      calm = (phase == 6);
      queue_random_samples(PHASE_ITEMS);
      wait_drained();
    end
    calm = 1'b0;

    repeat (100) @(posedge clk);
    if (expected_outputs.size() != 0)
      report_mismatch("result words never delivered", expected_outputs.size(), 0);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
